/* rtl/quoted_token_splitter_assert.svh */
// assertion macros for the quoted token splitter
`ifndef QUOTED_TOKEN_SPLITTER_ASSERT_SVH
`define QUOTED_TOKEN_SPLITTER_ASSERT_SVH
`ifndef SYNTHESIS
`define QTS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("qts assertion failed");
`define QTS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("qts assertion failed");
`else
`define QTS_ASSERT(lbl, clk, rst_n, prop)
`define QTS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* rtl/qts_pkg.sv */
// shared types and constants of the quoted token splitter
`timescale 1ns / 1ps
package qts_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = 2;
    localparam int CNT_W       = 3;

    typedef enum logic [1:0] {
        KIND_CHAR      = 2'd0,
        KIND_TOKEN_END = 2'd1,
        KIND_LINE_END  = 2'd2
    } kind_t;

    typedef struct packed {
        logic        two;
        kind_t       kind0;
        logic [7:0]  ch0;
        logic [5:0]  idx0;
        logic [5:0]  idx1;
    } entry_t;

endpackage

/* rtl/qts_front.sv */
// front end: character classification and token state
`timescale 1ns / 1ps
module qts_front #(
    parameter int MAX_TOKEN_LEN = 511,
    parameter int MAX_TOKENS    = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic            cfg_wdata,
    input  logic            accept,
    input  logic [7:0]      ch,
    input  logic            line_end,
    output logic            push,
    output qts_pkg::entry_t entry
);

    localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);
    localparam int CAP   = ((MAX_TOKENS - 1) < 63) ? (MAX_TOKENS - 1) : 63;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_PLAIN  = 2'd1,
        MODE_QUOTED = 2'd2,
        MODE_AFTER  = 2'd3
    } mode_t;

    mode_t            mode_reg, mode_next;
    logic             quote_single_reg, quote_single_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic             fold_reg;

    logic [7:0] c;
    logic [7:0] folded;
    logic [5:0] cnt_inc;
    logic       can_add;
    logic       is_space;
    logic       is_comma;
    logic       is_quote;
    logic       close_quote;

    always_comb
    begin
        c           = (ch == 8'd9) ? 8'd32 : ch;
        is_space    = (c == 8'd32);
        is_comma    = (c == 8'd44);
        is_quote    = (c == 8'd34) || (c == 8'd39);
        close_quote = quote_single_reg ? (c == 8'd39) : (c == 8'd34);
        folded      = (fold_reg && c >= 8'd65 && c <= 8'd90) ? (c | 8'd32) : c;
        cnt_inc     = (cnt_reg < 6'(CAP)) ? cnt_reg + 6'd1 : cnt_reg;
        can_add     = (len_reg < LEN_W'(MAX_TOKEN_LEN));

        mode_next         = mode_reg;
        quote_single_next = quote_single_reg;
        len_next          = len_reg;
        cnt_next          = cnt_reg;
        push              = 1'b0;
        entry.two         = 1'b0;
        entry.kind0       = qts_pkg::KIND_CHAR;
        entry.ch0         = 8'd0;
        entry.idx0        = cnt_reg;
        entry.idx1        = cnt_inc;

        if (line_end)
        begin
            push = 1'b1;
            if (mode_reg == MODE_PLAIN || mode_reg == MODE_QUOTED)
            begin
                entry.two   = 1'b1;
                entry.kind0 = qts_pkg::KIND_TOKEN_END;
            end
            else
            begin
                entry.kind0 = qts_pkg::KIND_LINE_END;
            end
            mode_next         = MODE_IDLE;
            quote_single_next = 1'b0;
            len_next          = '0;
            cnt_next          = '0;
        end
        else
        begin
            unique case (mode_reg) inside
                MODE_PLAIN, MODE_QUOTED:
                begin
                    if ((mode_reg == MODE_PLAIN && (is_space || is_comma)) ||
                        (mode_reg == MODE_QUOTED && close_quote))
                    begin
                        push        = 1'b1;
                        entry.kind0 = qts_pkg::KIND_TOKEN_END;
                        cnt_next    = cnt_inc;
                        len_next    = '0;
                        mode_next   = (mode_reg == MODE_PLAIN && is_comma) ?
                                      MODE_IDLE : MODE_AFTER;
                    end
                    else if (can_add)
                    begin
                        push      = 1'b1;
                        entry.ch0 = folded;
                        len_next  = len_reg + LEN_W'(1);
                    end
                end
                MODE_IDLE, MODE_AFTER:
                begin
                    if (is_space)
                    begin
                        mode_next = mode_reg;
                    end
                    else if (is_comma)
                    begin
                        // a comma with no token before it is an empty token
                        mode_next = MODE_IDLE;
                        if (mode_reg == MODE_IDLE)
                        begin
                            push        = 1'b1;
                            entry.kind0 = qts_pkg::KIND_TOKEN_END;
                            cnt_next    = cnt_inc;
                            len_next    = '0;
                        end
                    end
                    else if (is_quote)
                    begin
                        quote_single_next = (c == 8'd39);
                        mode_next         = MODE_QUOTED;
                        len_next          = '0;
                    end
                    else
                    begin
                        push      = 1'b1;
                        entry.ch0 = folded;
                        mode_next = MODE_PLAIN;
                        len_next  = LEN_W'(1);
                    end
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                end
            endcase
        end
        push = push && accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_IDLE;
            quote_single_reg <= 1'b0;
            len_reg          <= '0;
            cnt_reg          <= '0;
            fold_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                fold_reg <= cfg_wdata;
            end
            if (accept)
            begin
                mode_reg         <= mode_next;
                quote_single_reg <= quote_single_next;
                len_reg          <= len_next;
                cnt_reg          <= cnt_next;
            end
        end
    end

endmodule

/* rtl/qts_queue.sv */
// short queue of result requests between front and back
`timescale 1ns / 1ps
module qts_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  qts_pkg::entry_t wdata,
    input  logic            pop,
    output logic            full,
    output logic            nonempty,
    output qts_pkg::entry_t rdata
);

    qts_pkg::entry_t                    mem [qts_pkg::QUEUE_DEPTH];
    logic [qts_pkg::PTR_W-1:0]          wptr_reg;
    logic [qts_pkg::PTR_W-1:0]          rptr_reg;
    logic [qts_pkg::CNT_W-1:0]          count_reg;
    logic [qts_pkg::CNT_W-1:0]          count_next;

    assign full     = (count_reg == qts_pkg::CNT_W'(qts_pkg::QUEUE_DEPTH));
    assign nonempty = (count_reg != '0);
    assign rdata    = mem[rptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + qts_pkg::CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - qts_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + qts_pkg::PTR_W'(1);
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + qts_pkg::PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

/* rtl/qts_back.sv */
// back end: expands queued requests into result items
`timescale 1ns / 1ps
module qts_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  qts_pkg::entry_t q_data,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [1:0]      kind,
    output logic [7:0]      out_ch,
    output logic [5:0]      token_index,
    output logic            last
);

    logic           valid_reg;
    logic           phase_reg;
    qts_pkg::kind_t kind_reg;
    logic [7:0]     ch_reg;
    logic [5:0]     idx_reg;
    logic           last_reg;
    logic           load;

    assign load        = q_valid && (!valid_reg || !out_stall);
    assign pop         = load && (phase_reg || !q_data.two);
    assign out_valid   = valid_reg;
    assign kind        = kind_reg;
    assign out_ch      = ch_reg;
    assign token_index = idx_reg;
    assign last        = last_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (phase_reg)
            begin
                kind_reg <= qts_pkg::KIND_LINE_END;
                ch_reg   <= 8'd0;
                idx_reg  <= q_data.idx1;
                last_reg <= 1'b1;
            end
            else
            begin
                kind_reg <= q_data.kind0;
                ch_reg   <= q_data.ch0;
                idx_reg  <= q_data.idx0;
                last_reg <= !q_data.two;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                phase_reg <= !phase_reg && q_data.two;
            end
            else if (!out_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* rtl/quoted_token_splitter.sv */
// quoted token splitter: one line character per request in, token results out
// a request's first result is registered in the queue, then in the back end
// throughput: one request per cycle while in_stall is low; a line end that
// closes a token gives two results and holds the result port for both,
// absorbed by a 4-entry queue
// reset: asynchronous, clears scan state, token counters, queue and fold setting
`timescale 1ns / 1ps
`include "quoted_token_splitter_assert.svh"
module quoted_token_splitter #(
    parameter int MAX_TOKEN_LEN = 511,
    parameter int MAX_TOKENS    = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] ch,
    input  logic       line_end,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] kind,
    output logic [7:0] out_ch,
    output logic [5:0] token_index,
    output logic       last
);

    logic            accept;
    logic            push;
    logic            pop;
    logic            q_valid;
    qts_pkg::entry_t push_entry;
    qts_pkg::entry_t head_entry;

    assign accept = in_valid && !in_stall;

    qts_front #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
        .MAX_TOKENS    (MAX_TOKENS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .ch        (ch),
        .line_end  (line_end),
        .push      (push),
        .entry     (push_entry)
    );

    qts_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wdata    (push_entry),
        .pop      (pop),
        .full     (in_stall),
        .nonempty (q_valid),
        .rdata    (head_entry)
    );

    qts_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_data      (head_entry),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .out_ch      (out_ch),
        .token_index (token_index),
        .last        (last)
    );

    `QTS_ASSERT(a_pop_needs_data, clk, rst_n, pop |-> q_valid)
    `QTS_ASSERT(a_full_not_empty, clk, rst_n, in_stall |-> q_valid)
    `QTS_ASSERT(a_line_end_last, clk, rst_n, (out_valid && kind == qts_pkg::KIND_LINE_END) |-> last)
    `QTS_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> (!out_valid || $past(rst_n)))

endmodule

/* sim/quoted_token_splitter_tb.sv */
// self-checking testbench of the quoted token splitter
`timescale 1ns / 1ps
module quoted_token_splitter_tb;

    localparam int MAX_TOKEN_LEN = 511;
    localparam int MAX_TOKENS    = 64;
    localparam int TOKEN_CAP     = (MAX_TOKENS - 1 < 63) ? MAX_TOKENS - 1 : 63;
    localparam int DIR_N         = 25;
    localparam int PHASE_ITEMS   = 460;
    localparam int LONG_HOLD     = 400;

    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;

    typedef enum logic [1:0] {
        SCAN_IDLE   = 2'd0,
        SCAN_PLAIN  = 2'd1,
        SCAN_QUOTED = 2'd2,
        SCAN_AFTER  = 2'd3
    } scan_mode_t;

    typedef enum int {
        LINE_CLEAN,
        LINE_BROKEN,
        LINE_NOISE,
        LINE_CROWDED,
        LINE_LONG
    } line_style_t;

    typedef struct packed {
        qts_pkg::kind_t kind;
        logic [7:0]     ch;
        logic [5:0]     idx;
        logic           last;
    } tok_result_t;

    typedef struct packed {
        logic [7:0]  ch;
        logic        le;
        logic        typed;
        logic [1:0]  n;
        tok_result_t r0;
        tok_result_t r1;
    } dir_row_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       le;
    } line_byte_t;

    localparam tok_result_t NO_RESULT = '0;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    logic       cfg_wdata = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [7:0] ch        = 8'h00;
    logic       line_end  = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [1:0] kind;
    logic [7:0] out_ch;
    logic [5:0] token_index;
    logic       last;

    scan_mode_t  sc_mode   = SCAN_IDLE;
    logic        sc_single = 1'b0;
    int          sc_len    = 0;
    int          sc_count  = 0;
    logic        fold_en   = 1'b0;
    tok_result_t step_res [0:1];
    int          step_n;

    tok_result_t pending_results [$];
    line_byte_t  line_q [$];
    dir_row_t    dir_rows [0:DIR_N-1];

    int   mismatches = 0;
    logic idle_en    = 1'b1;
    logic hold_req   = 1'b0;
    logic hold_done  = 1'b0;
    int   hold_left  = 0;
    int   gap_left   = 0;

    quoted_token_splitter #(
        .MAX_TOKEN_LEN(MAX_TOKEN_LEN),
        .MAX_TOKENS   (MAX_TOKENS)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .ch         (ch),
        .line_end   (line_end),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .out_ch     (out_ch),
        .token_index(token_index),
        .last       (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic tok_result_t res(input qts_pkg::kind_t k, input logic [7:0] c,
                                        input int idx, input logic l);
        tok_result_t r;
        r.kind = k;
        r.ch   = c;
        r.idx  = 6'(idx);
        r.last = l;
        return r;
    endfunction

    function automatic dir_row_t row_typed(input logic [7:0] c, input logic le, input int n,
                                           input tok_result_t r0, input tok_result_t r1);
        dir_row_t r;
        r.ch    = c;
        r.le    = le;
        r.typed = 1'b1;
        r.n     = 2'(n);
        r.r0    = r0;
        r.r1    = r1;
        return r;
    endfunction

    function automatic dir_row_t row_pred(input logic [7:0] c, input logic le);
        dir_row_t r;
        r       = '0;
        r.ch    = c;
        r.le    = le;
        return r;
    endfunction

    function automatic logic [7:0] pick_plain(input logic first);
        logic [7:0] c;
        c = CH_SPACE;
        while (c == CH_SPACE || c == CH_TAB || c == CH_COMMA ||
               (first && (c == CH_DQUOTE || c == CH_SQUOTE)))
        begin
            if ($urandom_range(0, 1))
                c = 8'($urandom_range(CH_UPPER_A, CH_UPPER_Z) +
                       ($urandom_range(0, 1) ? 0 : 32));
            else
                c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    function automatic logic [7:0] pick_blank();
        return ($urandom_range(0, 3) == 0) ? CH_TAB : CH_SPACE;
    endfunction

    task emit(input qts_pkg::kind_t k, input logic [7:0] c);
        step_res[step_n] = res(k, c, sc_count, 1'b0);
        step_n = step_n + 1;
    endtask

    task token_char(input logic [7:0] c_in);
        logic [7:0] c;
        c = c_in;
        if (sc_len < MAX_TOKEN_LEN)
        begin
            sc_len = sc_len + 1;
            if (fold_en && c >= CH_UPPER_A && c <= CH_UPPER_Z)
                c = c | 8'h20;
            emit(qts_pkg::KIND_CHAR, c);
        end
    endtask

    task close_token();
        emit(qts_pkg::KIND_TOKEN_END, 8'h00);
        if (sc_count < TOKEN_CAP)
            sc_count = sc_count + 1;
        sc_len = 0;
    endtask

    task open_token(input logic [7:0] c);
        sc_len = 0;
        if (c == CH_DQUOTE || c == CH_SQUOTE)
        begin
            sc_single = (c == CH_SQUOTE);
            sc_mode   = SCAN_QUOTED;
        end
        else
        begin
            sc_mode = SCAN_PLAIN;
            token_char(c);
        end
    endtask

    task scan_request(input logic [7:0] c_in, input logic le);
        logic [7:0] c;
        c      = (c_in == CH_TAB) ? CH_SPACE : c_in;
        step_n = 0;
        if (le)
        begin
            if (sc_mode == SCAN_PLAIN || sc_mode == SCAN_QUOTED)
                close_token();
            emit(qts_pkg::KIND_LINE_END, 8'h00);
            sc_mode   = SCAN_IDLE;
            sc_single = 1'b0;
            sc_len    = 0;
            sc_count  = 0;
        end
        else
        begin
            case (sc_mode)
                SCAN_IDLE:
                begin
                    if (c == CH_COMMA)
                    begin
                        sc_len = 0;
                        close_token();
                    end
                    else if (c != CH_SPACE)
                        open_token(c);
                end
                SCAN_PLAIN:
                begin
                    if (c == CH_SPACE)
                    begin
                        close_token();
                        sc_mode = SCAN_AFTER;
                    end
                    else if (c == CH_COMMA)
                    begin
                        close_token();
                        sc_mode = SCAN_IDLE;
                    end
                    else
                        token_char(c);
                end
                SCAN_QUOTED:
                begin
                    if (c == (sc_single ? CH_SQUOTE : CH_DQUOTE))
                    begin
                        close_token();
                        sc_mode = SCAN_AFTER;
                    end
                    else
                        token_char(c);
                end
                default:
                begin
                    if (c == CH_COMMA)
                        sc_mode = SCAN_IDLE;
                    else if (c != CH_SPACE)
                        open_token(c);
                end
            endcase
        end
        if (step_n > 0)
            step_res[step_n-1].last = 1'b1;
    endtask

    task flag_mismatch(input string field, input int got_v, input int want_v);
        mismatches = mismatches + 1;
        if (mismatches <= 50)
            $display("mismatch %s: got %0d expected %0d at %0t", field, got_v, want_v, $time);
    endtask

    task add_expected(input tok_result_t r);
        pending_results.insert(pending_results.size(), r);
    endtask

    task check_result();
        tok_result_t want;
        if (pending_results.size() == 0)
            flag_mismatch("unexpected result kind", kind, 0);
        else
        begin
            want = pending_results.pop_front();
            if (kind !== want.kind)
                flag_mismatch("kind", kind, want.kind);
            if (out_ch !== want.ch)
                flag_mismatch("out_ch", out_ch, want.ch);
            if (token_index !== want.idx)
                flag_mismatch("token_index", token_index, want.idx);
            if (last !== want.last)
                flag_mismatch("last", last, want.last);
        end
    endtask

    task send_request(input dir_row_t r);
        if (idle_en && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid <= 1'b1;
        ch       <= r.ch;
        line_end <= r.le;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        scan_request(r.ch, r.le);
        if (r.typed)
        begin
            if (r.n > 0)
                add_expected(r.r0);
            if (r.n > 1)
                add_expected(r.r1);
        end
        else
            for (int i = 0; i < step_n; i++)
                add_expected(step_res[i]);
    endtask

    task push_byte(input logic [7:0] c, input logic le);
        line_byte_t b;
        b.ch = c;
        b.le = le;
        line_q.insert(line_q.size(), b);
    endtask

    task gen_line(input line_style_t style);
        int         ntok;
        int         sel;
        int         n;
        logic       comma;
        logic [7:0] q;
        logic [7:0] c;
        case (style) inside
            LINE_CLEAN, LINE_BROKEN:
            begin
                repeat ($urandom_range(0, 2)) push_byte(pick_blank(), 1'b0);
                ntok = $urandom_range(0, 6);
                for (int t = 0; t < ntok; t++)
                begin
                    sel = $urandom_range(0, 9);
                    if (sel < 5)
                    begin
                        n = $urandom_range(1, 10);
                        for (int i = 0; i < n; i++)
                            push_byte(pick_plain(i == 0), 1'b0);
                    end
                    else if (sel < 8)
                    begin
                        q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
                        push_byte(q, 1'b0);
                        repeat ($urandom_range(0, 8))
                        begin
                            c = 8'($urandom_range(0, 255));
                            while (c == q)
                                c = 8'($urandom_range(0, 255));
                            push_byte(c, 1'b0);
                        end
                        push_byte(q, 1'b0);
                    end
                    else
                        push_byte(CH_COMMA, 1'b0);
                    if (sel < 8)
                    begin
                        n     = $urandom_range(0, 2);
                        comma = ($urandom_range(0, 2) == 0);
                        if (sel < 5 && !comma && n == 0)
                            n = 1;
                        repeat (n) push_byte(pick_blank(), 1'b0);
                        if (comma)
                            push_byte(CH_COMMA, 1'b0);
                        repeat ($urandom_range(0, 1)) push_byte(pick_blank(), 1'b0);
                    end
                end
                if (style == LINE_BROKEN)
                begin
                    // unclosed quote or stray byte before the line end
                    if ($urandom_range(0, 1))
                    begin
                        push_byte($urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE, 1'b0);
                        repeat ($urandom_range(0, 5)) push_byte(pick_plain(1'b0), 1'b0);
                    end
                    else
                        push_byte(8'($urandom_range(0, 255)), 1'b0);
                end
            end
            LINE_NOISE:
            begin
                repeat ($urandom_range(1, 24))
                begin
                    case ($urandom_range(0, 9))
                        0: c = CH_SPACE;
                        1: c = CH_COMMA;
                        2: c = CH_DQUOTE;
                        3: c = CH_SQUOTE;
                        4: c = CH_TAB;
                        default: c = 8'($urandom_range(0, 255));
                    endcase
                    push_byte(c, ($urandom_range(0, 15) == 0));
                end
            end
            LINE_CROWDED:
            begin
                repeat ($urandom_range(60, 70))
                begin
                    if ($urandom_range(0, 1))
                        push_byte(pick_plain(1'b1), 1'b0);
                    push_byte(CH_COMMA, 1'b0);
                end
            end
            default:
            begin
                // plain token near or past MAX_TOKEN_LEN, then a short quoted one
                n = $urandom_range(MAX_TOKEN_LEN - 6, MAX_TOKEN_LEN + 9);
                for (int i = 0; i < n; i++)
                    push_byte(pick_plain(i == 0), 1'b0);
                push_byte(CH_SPACE, 1'b0);
                push_byte(CH_DQUOTE, 1'b0);
                repeat (3) push_byte(pick_plain(1'b0), 1'b0);
                push_byte(CH_DQUOTE, 1'b0);
            end
        endcase
        push_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task write_fold(input logic v);
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        fold_en = v;
    endtask

    task wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            check_result();
        if (hold_req && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (gap_left > 0)
        begin
            gap_left = gap_left - 1;
            out_stall <= 1'b1;
        end
        else if (idle_en && $urandom_range(0, 9) == 0)
        begin
            gap_left = $urandom_range(0, 12);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    initial
    begin
        #8_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int          r;
        int          sent;
        line_style_t style;
        line_byte_t  b;

        dir_rows[0]  = row_typed(8'h00, 1'b1, 1,
                                 res(qts_pkg::KIND_LINE_END, 8'h00, 0, 1'b1), NO_RESULT);
        dir_rows[1]  = row_typed(8'h41, 1'b0, 1,
                                 res(qts_pkg::KIND_CHAR, 8'h61, 0, 1'b1), NO_RESULT);
        dir_rows[2]  = row_typed(8'hFF, 1'b0, 1,
                                 res(qts_pkg::KIND_CHAR, 8'hFF, 0, 1'b1), NO_RESULT);
        dir_rows[3]  = row_typed(8'h00, 1'b0, 1,
                                 res(qts_pkg::KIND_CHAR, 8'h00, 0, 1'b1), NO_RESULT);
        dir_rows[4]  = row_pred(8'h71, 1'b0);
        dir_rows[5]  = row_typed(CH_TAB, 1'b0, 1,
                                 res(qts_pkg::KIND_TOKEN_END, 8'h00, 0, 1'b1), NO_RESULT);
        dir_rows[6]  = row_typed(CH_COMMA, 1'b0, 0, NO_RESULT, NO_RESULT);
        dir_rows[7]  = row_typed(CH_COMMA, 1'b0, 1,
                                 res(qts_pkg::KIND_TOKEN_END, 8'h00, 1, 1'b1), NO_RESULT);
        dir_rows[8]  = row_typed(CH_DQUOTE, 1'b0, 0, NO_RESULT, NO_RESULT);
        dir_rows[9]  = row_pred(8'h4D, 1'b0);
        dir_rows[10] = row_typed(CH_SPACE, 1'b0, 1,
                                 res(qts_pkg::KIND_CHAR, CH_SPACE, 2, 1'b1), NO_RESULT);
        dir_rows[11] = row_typed(CH_TAB, 1'b0, 1,
                                 res(qts_pkg::KIND_CHAR, CH_SPACE, 2, 1'b1), NO_RESULT);
        dir_rows[12] = row_pred(CH_SQUOTE, 1'b0);
        dir_rows[13] = row_pred(CH_COMMA, 1'b0);
        dir_rows[14] = row_typed(CH_DQUOTE, 1'b0, 1,
                                 res(qts_pkg::KIND_TOKEN_END, 8'h00, 2, 1'b1), NO_RESULT);
        dir_rows[15] = row_pred(8'h6B, 1'b0);
        dir_rows[16] = row_pred(CH_SPACE, 1'b0);
        dir_rows[17] = row_pred(CH_SQUOTE, 1'b0);
        dir_rows[18] = row_pred(CH_DQUOTE, 1'b0);
        // unclosed quote at line end
        dir_rows[19] = row_typed(8'h00, 1'b1, 2,
                                 res(qts_pkg::KIND_TOKEN_END, 8'h00, 4, 1'b0),
                                 res(qts_pkg::KIND_LINE_END, 8'h00, 5, 1'b1));
        dir_rows[20] = row_typed(8'h00, 1'b1, 1,
                                 res(qts_pkg::KIND_LINE_END, 8'h00, 0, 1'b1), NO_RESULT);
        dir_rows[21] = row_pred(CH_SPACE, 1'b0);
        dir_rows[22] = row_pred(CH_TAB, 1'b0);
        dir_rows[23] = row_typed(8'h00, 1'b1, 1,
                                 res(qts_pkg::KIND_LINE_END, 8'h00, 0, 1'b1), NO_RESULT);
        dir_rows[24] = row_typed(8'hA5, 1'b1, 1,
                                 res(qts_pkg::KIND_LINE_END, 8'h00, 0, 1'b1), NO_RESULT);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_fold(1'b1);

        for (int i = 0; i < DIR_N; i++)
            send_request(dir_rows[i]);
        in_valid <= 1'b0;

        for (int phase = 0; phase < 4; phase++)
        begin
            wait_drained();
            write_fold(phase[0]);
            idle_en = (phase != 3);
            if (phase == 1)
                hold_req = 1'b1;
            sent = 0;
            if (phase == 2)
                gen_line(LINE_LONG);
            while (sent < PHASE_ITEMS)
            begin
                if (line_q.size() == 0)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 65)
                        style = LINE_CLEAN;
                    else if (r < 80)
                        style = LINE_BROKEN;
                    else if (r < 95)
                        style = LINE_NOISE;
                    else
                        style = LINE_CROWDED;
                    gen_line(style);
                end
                while (line_q.size() != 0)
                begin
                    b = line_q.pop_front();
                    send_request(row_pred(b.ch, b.le));
                    sent = sent + 1;
                end
            end
            in_valid <= 1'b0;
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
